// ===== src/gsx_pkg.sv =====
// Package with the shared constants and word types of the grid subset-XOR-sum block.
`timescale 1ns / 1ps
`default_nettype none
package gsx_pkg;

  localparam int ROWS_DEF       = 16;
  localparam int COLS_DEF       = 16;
  localparam int VALUE_BITS_DEF = 60;
  localparam int FIELD_W        = 5;
  localparam int SUM_W          = 30;
  localparam logic [SUM_W-1:0] MODULUS = 30'd1000000007;

  localparam int CFG_AW = 3;
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [59:0]        value;
    logic [FIELD_W-1:0] row_end;
    logic [FIELD_W-1:0] col_end;
  } in_word_t;

  typedef struct packed {
    logic [SUM_W-1:0] subset_xor_sum;
    logic             bad_range;
  } out_word_t;

endpackage
`default_nettype wire

// ===== src/grid_rect_subset_xor_sum.sv =====
// Top level of the grid subset-XOR-sum block: sequencer, configuration and channels.
//
// The input channel takes one word per item: a set action writes one cell of the grid,
// a query action names a rectangle and gives one result word on the output channel.
// Sets outside the grid in use are dropped and give no word. The APB-style
// configuration port holds the rows and columns in use (byte addresses 0 and 4).
// A bad rectangle gives its word in the cycle after acceptance. A good query of T
// cells reads the cell memory one cell a cycle to OR the values together, then runs
// the modular shift unit, which shifts in one bit a cycle, to scale the OR into the result.
// While a query is in progress, or its word waits, in_stall is high. The result word
// sits in an output register until the receiver lowers out_stall; the next input word
// can be taken in the cycle after the result word is accepted.
// Reset clears the sequencer, the valid bits of all cells (so every cell reads as zero)
// and sets both in-use registers to 16, the default grid size; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module grid_rect_subset_xor_sum import gsx_pkg::*; #(
  parameter int ROWS       = ROWS_DEF,
  parameter int COLS       = COLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_word_t              out_word,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int STEP_W = $clog2(VALUE_BITS + DEPTH + 1);
  localparam int DIM_W  = 9;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t st_r, st_nxt;

  // Configuration registers.
  logic [FIELD_W-1:0] rows_r, cols_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= FIELD_W'(16);
      cols_r <= FIELD_W'(16);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ROWS: rows_r <= cfg_pwdata[FIELD_W-1:0];
        REG_COLS: cols_r <= cfg_pwdata[FIELD_W-1:0];
        default:  rows_r <= rows_r;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_COLS) ? {27'd0, cols_r} : {27'd0, rows_r};

  // Limits in use: a register above the grid size acts as the grid size.
  logic [DIM_W-1:0] nrows, ncols, r1, c1, r2, c2;
  assign nrows = ({4'd0, rows_r} > DIM_W'(ROWS)) ? DIM_W'(ROWS) : {4'd0, rows_r};
  assign ncols = ({4'd0, cols_r} > DIM_W'(COLS)) ? DIM_W'(COLS) : {4'd0, cols_r};
  assign r1 = {4'd0, in_word.row};
  assign c1 = {4'd0, in_word.col};
  assign r2 = {4'd0, in_word.row_end};
  assign c2 = {4'd0, in_word.col_end};

  logic in_acc, set_ok, query_bad;
  assign in_acc    = in_valid && !in_stall;
  assign set_ok    = (r1 != '0) && (c1 != '0) && (r1 <= nrows) && (c1 <= ncols);
  assign query_bad = (r1 == '0) || (c1 == '0) || (r1 > r2) || (c1 > c2) ||
                     (r2 > nrows) || (c2 > ncols);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    logic [31:0] a;
    a = ({23'd0, r} - 32'd1) * 32'(COLS) + ({23'd0, c} - 32'd1);
    return a[ADDR_W-1:0];
  endfunction

  // Rectangle walk state.
  logic [DIM_W-1:0]      cr_r, cr_nxt, cc_r, cc_nxt;
  logic [DIM_W-1:0]      rb_r, rb_nxt, ce_r, ce_nxt, cs_r, cs_nxt;
  logic [VALUE_BITS-1:0] or_r, or_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  pend_r, pend_nxt;
  out_word_t             ow_r, ow_nxt;

  logic                  wr_en, rd_en, mul_start, mul_done;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic [STEP_W-1:0]     mul_steps;
  logic [SUM_W-1:0]      mul_res;

  assign wr_en   = in_acc && (in_word.action == ACT_SET) && set_ok;
  assign wr_addr = cell_addr(r1, c1);
  assign rd_en   = (st_r == ST_SCAN);
  assign rd_addr = cell_addr(cr_r, cc_r);

  always_comb begin
    st_nxt    = st_r;
    cr_nxt    = cr_r;
    cc_nxt    = cc_r;
    rb_nxt    = rb_r;
    ce_nxt    = ce_r;
    cs_nxt    = cs_r;
    or_nxt    = or_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = 1'b0;
    ow_nxt    = ow_r;
    mul_start = 1'b0;
    mul_steps = STEP_W'(VALUE_BITS) + STEP_W'(cnt_r) - STEP_W'(1);
    // Fold in the word read in the previous cycle.
    if (pend_r) begin
      or_nxt  = or_r | rd_data;
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc && (in_word.action == ACT_QUERY)) begin
          if (query_bad) begin
            ow_nxt = '{subset_xor_sum: '0, bad_range: 1'b1};
            st_nxt = ST_OUT;
          end else begin
            cr_nxt  = r1;
            cc_nxt  = c1;
            cs_nxt  = c1;
            ce_nxt  = c2;
            rb_nxt  = r2;
            or_nxt  = '0;
            cnt_nxt = '0;
            st_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pend_nxt = 1'b1;
        if (cc_r == ce_r) begin
          cc_nxt = cs_r;
          cr_nxt = cr_r + DIM_W'(1);
          if (cr_r == rb_r) begin
            st_nxt = ST_DRAIN;
          end
        end else begin
          cc_nxt = cc_r + DIM_W'(1);
        end
      end
      ST_DRAIN: begin
        // The last read lands now; the cell count includes it.
        mul_start = 1'b1;
        mul_steps = STEP_W'(VALUE_BITS) + STEP_W'(cnt_nxt) - STEP_W'(1);
        st_nxt    = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          ow_nxt = '{subset_xor_sum: mul_res, bad_range: 1'b0};
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
    end
    cr_r  <= cr_nxt;
    cc_r  <= cc_nxt;
    rb_r  <= rb_nxt;
    ce_r  <= ce_nxt;
    cs_r  <= cs_nxt;
    or_r  <= or_nxt;
    cnt_r <= cnt_nxt;
    ow_r  <= ow_nxt;
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_word  = ow_r;

  gsx_cell_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (VALUE_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_word.value[VALUE_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The sum over subsets is 2^(T-1) times the OR of the cells, taken mod p.
  gsx_modshift #(
    .DATA_W (VALUE_BITS),
    .STEP_W (STEP_W)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (or_nxt),
    .steps   (mul_steps),
    .done    (mul_done),
    .result  (mul_res)
  );

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bad_range |-> out_word.subset_xor_sum == '0)
    else $error("bad rectangle word carries a nonzero sum");
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.subset_xor_sum < MODULUS)
    else $error("result not reduced below the modulus");
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> st_r == ST_MUL)
    else $error("modular unit finished outside its state");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> st_r == ST_IDLE)
    else $error("cell write while a query is in progress");
`endif

endmodule
`default_nettype wire

// ===== src/gsx_cell_mem.sv =====
// Cell value memory with one valid bit per cell and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module gsx_cell_mem import gsx_pkg::*; #(
  parameter int DEPTH  = ROWS_DEF * COLS_DEF,
  parameter int DATA_W = VALUE_BITS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] dat_r;
  logic              hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      dat_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= vld_r[rd_addr];
      end
    end
  end

  // A cell never written since reset reads as zero.
  assign rd_data = hit_r ? dat_r : '0;

endmodule
`default_nettype wire

// ===== src/gsx_modshift.sv =====
// Modular unit: shifts bits into an accumulator as acc = 2*acc + bit mod p.
`timescale 1ns / 1ps
`default_nettype none
module gsx_modshift import gsx_pkg::*; #(
  parameter int DATA_W = VALUE_BITS_DEF,
  parameter int STEP_W = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] operand,
  input  wire logic [STEP_W-1:0] steps,
  output logic                   done,
  output logic      [SUM_W-1:0]  result
);

  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [DATA_W-1:0] sh_r, sh_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SUM_W:0]    dbl;

  // Operand bits go in MSB first, then zeros: the total is operand * 2^(steps-DATA_W).
  assign dbl = {acc_r, sh_r[DATA_W-1]};

  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      sh_nxt   = operand;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (dbl >= {1'b0, MODULUS}) ? SUM_W'(dbl - {1'b0, MODULUS}) : dbl[SUM_W-1:0];
      sh_nxt  = {sh_r[DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule
`default_nettype wire
